@@ rtl/core/spr_pkg.sv @@
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the servo pulse ramp core.
// ----------------------------------------------------------------------------
package spr_pkg;

	localparam int WIDTH_W   = 12;
	localparam int DUR_W     = 16;
	localparam int CNT_W     = 12;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 2;
	// |delta| * step * period fits in 29 bits
	localparam int PROD_W    = 29;
	localparam int DIV_CNT_W = 5;

	localparam int STEP_PERIOD_MS = 20;

	localparam logic [WIDTH_W-1:0] LIMIT_A_RST = WIDTH_W'(500);
	localparam logic [WIDTH_W-1:0] LIMIT_B_RST = WIDTH_W'(2500);
	localparam logic [WIDTH_W-1:0] WIDTH_RST   = WIDTH_W'(1500);
	localparam logic [DUR_W-1:0]   DUR_MIN     = DUR_W'(STEP_PERIOD_MS);

	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_B = 2'd1;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK   = 2'd0,
		MODE_SMOOTH = 2'd1,
		MODE_JUMP   = 2'd2,
		MODE_RSVD   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DSTART,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	// handshake between sequencer and serial divider
	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [DUR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ rtl/core/spr_div.sv @@
// ----------------------------------------------------------------------------
// spr_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  spr_pkg::div_req_t req,
	output spr_pkg::div_rsp_t rsp
);

	logic                              busy_q;
	logic                              done_q;
	logic [spr_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [spr_pkg::DUR_W-1:0]         rem_q;
	logic [spr_pkg::PROD_W-1:0]        quo_q;
	logic [spr_pkg::DUR_W-1:0]         dvs_q;
	logic [spr_pkg::DUR_W:0]           trial;
	logic                              fits;

	assign trial = {rem_q, quo_q[spr_pkg::PROD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= spr_pkg::DIV_CNT_W'(spr_pkg::PROD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// dividend bits shift out the top while quotient bits enter below
			if (fits) begin
				rem_q <= spr_pkg::DUR_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[spr_pkg::DUR_W-1:0];
			end
			quo_q <= {quo_q[spr_pkg::PROD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ rtl/core/servo_pulse_ramp_core.sv @@
// ----------------------------------------------------------------------------
// servo_pulse_ramp_core
// Linear pulse-width ramp for a hobby servo with clamp limits.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake               | payload
//  s_axis    | in  | s_axis_tvalid/tready    | tuser: mode; tdata: target, duration
//  m_axis    | out | m_axis_tvalid/tready    | tdata: pulse_width, moving, move_done
//  cfg       | in  | cfg_valid/cfg_ready     | cfg_index, cfg_data (limits)
//
// commands that need no ramp step go straight from idle to the output state; a ramp
// step passes through the multiply state and then the 29-bit serial divide (one
// quotient bit per cycle) before its result is taken into the output register
// one item is in work at a time; the input is ready again once the result
// is handed to the output register, which holds while m_axis_tready is low
// reset restores the default limits, width 1500 and no active ramp
module servo_pulse_ramp_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [11:0] target_width, [27:12] duration_ms
	input  logic [1:0]  s_axis_tuser,   // [1:0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [11:0] pulse_width, [12] moving, [13] move_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int W = spr_pkg::WIDTH_W;

	spr_pkg::state_t state_q, state_d;

	logic [W-1:0]              limit_a_q, limit_b_q;
	logic [W-1:0]              cur_q, start_q, goal_q;
	logic [spr_pkg::DUR_W-1:0] dur_q;
	logic [spr_pkg::CNT_W-1:0] step_q;
	logic                      active_q;
	logic                      done_q;
	logic [spr_pkg::PROD_W-1:0] prod_q;

	logic                      out_valid_q;
	logic [15:0]               out_data_q;

	logic                      in_fire;
	logic                      out_load;
	logic                      step_needed;
	spr_pkg::mode_t            mode;
	logic [W-1:0]              target;
	logic [spr_pkg::DUR_W-1:0] duration;
	logic [W-1:0]              lo, hi;
	logic [W-1:0]              target_clamped;
	logic [W-1:0]              mag;
	logic                      neg;
	logic [2*W-1:0]            mul;
	logic [W-1:0]              qcap;
	logic [W-1:0]              next_w;
	logic [W-1:0]              next_clamped;

	spr_pkg::div_req_t div_req;
	spr_pkg::div_rsp_t div_rsp;

	function automatic logic [W-1:0] clamp(input logic [W-1:0] w,
		input logic [W-1:0] l, input logic [W-1:0] h);
		logic [W-1:0] r;
		r = w;
		if (w < l) r = l;
		else if (w > h) r = h;
		return r;
	endfunction

	assign mode     = spr_pkg::mode_t'(s_axis_tuser);
	assign target   = s_axis_tdata[11:0];
	assign duration = s_axis_tdata[27:12];

	assign lo = (limit_a_q < limit_b_q) ? limit_a_q : limit_b_q;
	assign hi = (limit_a_q < limit_b_q) ? limit_b_q : limit_a_q;
	assign target_clamped = clamp(target, lo, hi);

	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// a tick or a smooth move that really ramps needs the multiply and divide
	always_comb begin
		step_needed = 1'b0;
		unique case (mode)
			spr_pkg::MODE_TICK:   step_needed = active_q && (goal_q != cur_q);
			spr_pkg::MODE_SMOOTH: step_needed = (target_clamped != cur_q);
			spr_pkg::MODE_JUMP:   step_needed = 1'b0;
			spr_pkg::MODE_RSVD:   step_needed = 1'b0;
			default:              step_needed = 1'b0;
		endcase
	end

	// ramp arithmetic
	assign neg = goal_q < start_q;
	assign mag = neg ? (start_q - goal_q) : (goal_q - start_q);
	assign mul = mag * step_q;
	assign qcap = (div_rsp.quotient >= {{(spr_pkg::PROD_W-W){1'b0}}, mag})
		? mag : div_rsp.quotient[W-1:0];
	assign next_w = neg ? (start_q - qcap) : (start_q + qcap);
	assign next_clamped = clamp(next_w, lo, hi);

	spr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		s_axis_tready    = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = dur_q;
		out_load         = 1'b0;
		unique case (state_q)
			spr_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = step_needed ? spr_pkg::ST_MUL : spr_pkg::ST_OUT;
				end
			end
			spr_pkg::ST_MUL: begin
				state_d = spr_pkg::ST_DSTART;
			end
			spr_pkg::ST_DSTART: begin
				div_req.start = 1'b1;
				state_d = spr_pkg::ST_DIV;
			end
			spr_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = spr_pkg::ST_FIN;
				end
			end
			spr_pkg::ST_FIN: begin
				state_d = spr_pkg::ST_OUT;
			end
			spr_pkg::ST_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = spr_pkg::ST_IDLE;
				end
			end
			default: state_d = spr_pkg::ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_a_q   <= spr_pkg::LIMIT_A_RST;
			limit_b_q   <= spr_pkg::LIMIT_B_RST;
			cur_q       <= spr_pkg::WIDTH_RST;
			start_q     <= '0;
			goal_q      <= spr_pkg::WIDTH_RST;
			dur_q       <= '0;
			step_q      <= '0;
			active_q    <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == spr_pkg::REG_LIMIT_A) begin
					limit_a_q <= cfg_data;
				end else if (cfg_index == spr_pkg::REG_LIMIT_B) begin
					limit_b_q <= cfg_data;
				end
			end

			if (in_fire) begin
				done_q <= 1'b0;
				unique case (mode)
					spr_pkg::MODE_TICK: begin
						if (active_q) begin
							if (goal_q == cur_q) begin
								active_q <= 1'b0;
								done_q   <= 1'b1;
							end else if (step_q != '1) begin
								step_q <= step_q + 1'b1;
							end
						end
					end
					spr_pkg::MODE_SMOOTH: begin
						start_q <= cur_q;
						goal_q  <= target_clamped;
						if (target_clamped != cur_q) begin
							dur_q    <= (duration < spr_pkg::DUR_MIN) ? spr_pkg::DUR_MIN
								: duration;
							step_q   <= spr_pkg::CNT_W'(1);
							active_q <= 1'b1;
						end
					end
					spr_pkg::MODE_JUMP: begin
						if (target != cur_q) begin
							cur_q <= target_clamped;
						end
					end
					spr_pkg::MODE_RSVD: begin
					end
					default: begin
					end
				endcase
			end

			if (state_q == spr_pkg::ST_FIN && next_w != cur_q) begin
				cur_q <= next_clamped;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == spr_pkg::ST_MUL) begin
			// times the 20 ms step period as x*16 + x*4
			prod_q <= {{(spr_pkg::PROD_W-2*W-4){1'b0}}, mul, 4'b0000}
				+ {{(spr_pkg::PROD_W-2*W-2){1'b0}}, mul, 2'b00};
		end
		if (out_load) begin
			out_data_q <= {2'b00, done_q, active_q, cur_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the servo pulse ramp core: commands go in on the
// input stream, and a local ramp predictor checks every width, moving and done
// flag that comes out, under several limit settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		spr_pkg::mode_t mode;
		logic [11:0]    target;
		logic [15:0]    dur_ms;
	} servo_cmd_t;

	typedef struct packed {
		logic [11:0]  pulse_width;
		logic         moving;
		logic         move_done;
	} ramp_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [11:0] target_width, [27:12] duration_ms
	logic [1:0]  s_axis_tuser = '0;   // [1:0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // [11:0] pulse_width, [12] moving, [13] move_done
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;

	servo_cmd_t   cmd_q[$];
	ramp_result_t ramp_expect_q[$];
	servo_cmd_t   bus_cmd;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           mismatch_cnt = 0;

	// predictor state
	logic [11:0]  lim_a = spr_pkg::LIMIT_A_RST;
	logic [11:0]  lim_b = spr_pkg::LIMIT_B_RST;
	logic [11:0]  cur_w = spr_pkg::WIDTH_RST;
	logic [11:0]  start_w = '0;
	logic [11:0]  goal_w = spr_pkg::WIDTH_RST;
	logic [15:0]  ramp_dur = '0;
	logic [11:0]  step_cnt = '0;
	logic         ramp_on = 1'b0;

	servo_pulse_ramp_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [11:0] clamp_to_limits(logic [11:0] w);
		logic [11:0] lo, hi;
		lo = (lim_a < lim_b) ? lim_a : lim_b;
		hi = (lim_a < lim_b) ? lim_b : lim_a;
		if (w < lo)
			return lo;
		if (w > hi)
			return hi;
		return w;
	endfunction

	// a width equal to the current one leaves it alone, even outside the limits
	function automatic void move_width(logic [11:0] w);
		if (w != cur_w)
			cur_w = clamp_to_limits(w);
	endfunction

	function automatic void advance_ramp();
		longint delta, quot, nxt;
		if (goal_w == cur_w)
			return;
		if (step_cnt != 12'hFFF)
			step_cnt++;
		delta = longint'(goal_w) - longint'(start_w);
		quot = (delta * longint'(step_cnt) * spr_pkg::STEP_PERIOD_MS) /
			longint'(ramp_dur);
		nxt = longint'(start_w) + quot;
		if (delta > 0) begin
			if (nxt > longint'(goal_w))
				nxt = longint'(goal_w);
		end else begin
			if (nxt < longint'(goal_w))
				nxt = longint'(goal_w);
		end
		if (nxt < 0)
			nxt = 0;
		move_width(nxt[11:0]);
	endfunction

	function automatic ramp_result_t apply_cmd(servo_cmd_t c);
		ramp_result_t r;
		logic         done;
		done = 1'b0;
		case (c.mode)
			spr_pkg::MODE_TICK: begin
				if (ramp_on) begin
					if (goal_w == cur_w) begin
						ramp_on = 1'b0;
						done = 1'b1;
					end else begin
						advance_ramp();
					end
				end
			end
			spr_pkg::MODE_SMOOTH: begin
				start_w = cur_w;
				goal_w = clamp_to_limits(c.target);
				if (start_w != goal_w) begin
					ramp_dur = (c.dur_ms < spr_pkg::DUR_MIN) ? spr_pkg::DUR_MIN : c.dur_ms;
					step_cnt = '0;
					ramp_on = 1'b1;
					advance_ramp();
				end
			end
			spr_pkg::MODE_JUMP: move_width(c.target);
			default: ;
		endcase
		r.pulse_width = cur_w;
		r.moving = ramp_on;
		r.move_done = done;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t: %s", $time, what);
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid)
				ramp_expect_q.push_back(apply_cmd(bus_cmd));
			if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				bus_cmd = cmd_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {4'b0, bus_cmd.dur_ms, bus_cmd.target};
				s_axis_tuser <= bus_cmd.mode;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		ramp_result_t want;
		ramp_result_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.pulse_width = m_axis_tdata[11:0];
				got.moving = m_axis_tdata[12];
				got.move_done = m_axis_tdata[13];
				if (ramp_expect_q.size() == 0) begin
					report_mismatch($sformatf(
						"result with nothing pending: width %0d moving %0b done %0b",
						got.pulse_width, got.moving, got.move_done));
				end else begin
					want = ramp_expect_q.pop_front();
					if (got.pulse_width != want.pulse_width || got.moving != want.moving ||
							got.move_done != want.move_done)
						report_mismatch($sformatf(
							"width %0d/%0d moving %0b/%0b done %0b/%0b (expected/actual)",
							want.pulse_width, got.pulse_width, want.moving, got.moving,
							want.move_done, got.move_done));
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic push_cmd(spr_pkg::mode_t m, logic [11:0] t, logic [15:0] d);
		servo_cmd_t c;
		c.mode = m;
		c.target = t;
		c.dur_ms = d;
		cmd_q.push_back(c);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [11:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == spr_pkg::REG_LIMIT_A)
			lim_a = val;
		else if (idx == spr_pkg::REG_LIMIT_B)
			lim_b = val;
	endtask

	// wait until every command is in and every result is out, then let the core settle
	task automatic wait_idle();
		while (cmd_q.size() != 0 || s_axis_tvalid || ramp_expect_q.size() != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [11:0] pick_target();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 12'd0;
		if (r < 30)
			return 12'hFFF;
		if (r < 40)
			return ($urandom_range(1)) ? lim_a : lim_b;
		return 12'($urandom);
	endfunction

	function automatic logic [15:0] pick_duration();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 16'($urandom_range(19));
		if (r < 85)
			return 16'($urandom_range(20, 200));
		return 16'($urandom);
	endfunction

	// mostly smooth moves followed by the ticks that carry them out, between single jumps, ticks and reserved commands
	task automatic add_random_cmds(int n);
		int          left;
		int          r;
		int          ticks;
		logic [15:0] d;
		left = n;
		while (left > 0) begin
			r = $urandom_range(99);
			if (r < 40) begin
				d = pick_duration();
				push_cmd(spr_pkg::MODE_SMOOTH, pick_target(), d);
				ticks = (d <= 200) ? d / 20 + $urandom_range(2) : $urandom_range(1, 10);
				left -= ticks + 1;
				repeat (ticks) begin
					if ($urandom_range(99) < 8)
						push_cmd(spr_pkg::MODE_JUMP, pick_target(), 16'($urandom));
					else
						push_cmd(spr_pkg::MODE_TICK, 12'($urandom), 16'($urandom));
				end
			end else begin
				if (r < 60)
					push_cmd(spr_pkg::MODE_JUMP, pick_target(), 16'($urandom));
				else if (r < 65)
					push_cmd(spr_pkg::MODE_RSVD, 12'($urandom), 16'($urandom));
				else
					push_cmd(spr_pkg::MODE_TICK, 12'($urandom), 16'($urandom));
				left--;
			end
		end
	endtask

	initial begin
		int          idle_tbl[5];
		int          stall_tbl[5];
		logic [11:0] a_tbl[5];
		logic [11:0] b_tbl[5];
		idle_tbl = '{0, 69, 0, 13, 0};
		stall_tbl = '{0, 0, 69, 13, 0};
		a_tbl = '{12'd0, 12'hFFF, 12'($urandom), 12'($urandom_range(600, 3000)), 12'($urandom)};
		b_tbl = '{12'hFFF, 12'd0, 12'($urandom), 12'd0, 12'($urandom)};
		b_tbl[3] = a_tbl[3];

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset limits, no idling
		push_cmd(spr_pkg::MODE_TICK, 12'hFFF, 16'hFFFF);
		push_cmd(spr_pkg::MODE_RSVD, 12'hABC, 16'h1234);
		push_cmd(spr_pkg::MODE_JUMP, 12'd1500, 16'd0);
		push_cmd(spr_pkg::MODE_JUMP, 12'hFFF, 16'd0);
		push_cmd(spr_pkg::MODE_JUMP, 12'd0, 16'd0);
		push_cmd(spr_pkg::MODE_SMOOTH, 12'hFFF, 16'd0);
		push_cmd(spr_pkg::MODE_TICK, 12'd0, 16'd0);
		push_cmd(spr_pkg::MODE_TICK, 12'd0, 16'd0);
		push_cmd(spr_pkg::MODE_SMOOTH, 12'd1000, 16'd100);
		push_cmd(spr_pkg::MODE_JUMP, 12'd2000, 16'd0);
		push_cmd(spr_pkg::MODE_TICK, 12'd0, 16'd0);
		// smooth move onto the width it already has while a ramp runs
		push_cmd(spr_pkg::MODE_SMOOTH, 12'd1900, 16'd5);
		push_cmd(spr_pkg::MODE_TICK, 12'd0, 16'd0);
		push_cmd(spr_pkg::MODE_SMOOTH, 12'hFFF, 16'hFFFF);
		repeat (3) push_cmd(spr_pkg::MODE_TICK, 12'd0, 16'd0);
		push_cmd(spr_pkg::MODE_RSVD, 12'd0, 16'd0);
		wait_idle();

		// narrow the limits mid ramp so the goal is out of reach
		write_reg(spr_pkg::REG_LIMIT_A, 12'd2200);
		write_reg(spr_pkg::REG_LIMIT_B, 12'd2000);
		push_cmd(spr_pkg::MODE_JUMP, 12'd1900, 16'd0);
		repeat (20) push_cmd(spr_pkg::MODE_TICK, 12'($urandom), 16'($urandom));
		wait_idle();

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(spr_pkg::REG_LIMIT_A, a_tbl[ph]);
			write_reg(spr_pkg::REG_LIMIT_B, b_tbl[ph]);
			send_idle_pct = idle_tbl[ph];
			recv_stall_pct = stall_tbl[ph];
			add_random_cmds(70);
			wait_idle();
		end

		while (ramp_expect_q.size() != 0) begin
			void'(ramp_expect_q.pop_front());
			report_mismatch("expected result never arrived");
		end
		if (mismatch_cnt == 0)
			$display("servo_pulse_ramp_core: match");
		else
			$display("servo_pulse_ramp_core: mismatch");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("servo_pulse_ramp_core: mismatch");
		$finish;
	end

endmodule
